FILE: rtl/heartbeat_overdue_monitor_unit_macros.svh
// Assertion helpers used by the checker file.
`ifndef HEARTBEAT_OVERDUE_MONITOR_UNIT_MACROS_SVH
`define HEARTBEAT_OVERDUE_MONITOR_UNIT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define HOM_ASSERT_IMPL(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define HOM_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that is checked through reset as well.
`define HOM_ASSERT_RESET(label, ante, cons, msg) \
    label: assert property (@(posedge aclk) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: rtl/hom_pkg.sv
package hom_pkg;

    localparam logic [1:0] MODE_DEFINE = 2'd0;
    localparam logic [1:0] MODE_UPDATE = 2'd1;
    localparam logic [1:0] MODE_CHECK  = 2'd2;

    localparam int SLOT_W  = 3;
    localparam int DELAY_W = 32;

    // Decision of the entry rules for one table access.
    typedef struct packed {
        logic write;
        logic report;
    } act_t;

endpackage

FILE: rtl/hom_mem.sv
module hom_mem #(
    parameter int DEPTH  = 8,
    parameter int WIDTH  = 128,
    parameter int ADDR_W = 3
) (
    input  logic              aclk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem_array [DEPTH];
    logic [WIDTH-1:0] rd_data_reg;

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_array[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem_array[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

FILE: rtl/hom_rules.sv
module hom_rules #(
    parameter int TIME_BITS = 32
) (
    input  logic [1:0]           mode,
    input  logic                 ent_valid,
    input  logic [TIME_BITS-1:0] t,
    input  logic [TIME_BITS-1:0] ivl,
    input  logic [TIME_BITS-1:0] period,
    input  logic [TIME_BITS-1:0] seen,
    input  logic [TIME_BITS-1:0] pending,
    input  logic [TIME_BITS-1:0] reported,
    output hom_pkg::act_t        act,
    output logic [TIME_BITS-1:0] period_new,
    output logic [TIME_BITS-1:0] seen_new,
    output logic [TIME_BITS-1:0] pending_new,
    output logic [TIME_BITS-1:0] reported_new,
    output logic [TIME_BITS-1:0] delay
);

    logic [TIME_BITS-1:0] gap_seen;
    logic [TIME_BITS-1:0] gap_rep;
    logic                 quiet;

    assign gap_seen = t - seen;
    assign gap_rep  = t - reported;
    // Silent too long both since the last heartbeat and since the last report.
    assign quiet = (t > seen) && (gap_seen > period) && (t > reported) && (gap_rep > period);

    always_comb begin
        act          = '0;
        period_new   = period;
        seen_new     = seen;
        pending_new  = pending;
        reported_new = reported;
        delay        = '0;
        case (mode)
            hom_pkg::MODE_DEFINE: begin
                act.write  = 1'b1;
                period_new = ivl;
                if (!ent_valid) begin
                    seen_new     = t;
                    pending_new  = '0;
                    reported_new = '0;
                end
            end
            hom_pkg::MODE_UPDATE: begin
                act.write = ent_valid;
                seen_new  = t;
                if (quiet) begin
                    pending_new = gap_seen;
                end
            end
            hom_pkg::MODE_CHECK: begin
                if (ent_valid && (pending != '0)) begin
                    act.write    = 1'b1;
                    act.report   = 1'b1;
                    delay        = pending;
                    pending_new  = '0;
                    reported_new = t;
                end else if (ent_valid && quiet) begin
                    act.write    = 1'b1;
                    act.report   = 1'b1;
                    delay        = gap_seen;
                    pending_new  = '0;
                    reported_new = t - TIME_BITS'(1);
                end
            end
            default: begin
                act = '0;
            end
        endcase
    end

endmodule

FILE: rtl/heartbeat_overdue_monitor_unit.sv
// Define and update requests go through accept, table read and write back.
// A check request reads and evaluates one table entry per cycle through the
// single read port, unless a second report waits on a stalled output, plus a final result step.
// Results leave through an output register.
// Reset (aresetn low at a clock edge) clears all entry valid bits and control state.
module heartbeat_overdue_monitor_unit #(
    parameter int NUM_ENTRIES = 8,
    parameter int TIME_BITS   = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [1:0]  s_mode,
    input  logic [2:0]  s_slot,
    input  logic [31:0] s_time_value,
    input  logic [31:0] s_interval_value,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [2:0]  m_entry_slot,
    output logic [31:0] m_overdue_time,
    output logic        m_found,
    output logic        m_last
);

    localparam int IDX_W = (NUM_ENTRIES > 1) ? $clog2(NUM_ENTRIES) : 1;
    localparam int ROW_W = 4 * TIME_BITS;
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(NUM_ENTRIES - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_EVAL,
        ST_FINISH
    } state_t;

    state_t                         state_reg, state_next;
    logic [1:0]                     mode_reg, mode_next;
    logic [IDX_W-1:0]               slot_reg, slot_next;
    logic [IDX_W-1:0]               scan_idx_reg, scan_idx_next;
    logic [TIME_BITS-1:0]           time_reg, time_next;
    logic [TIME_BITS-1:0]           ivl_reg, ivl_next;
    logic [NUM_ENTRIES-1:0]         valid_reg, valid_next;
    logic                           hold_valid_reg, hold_valid_next;
    logic [hom_pkg::SLOT_W-1:0]     hold_slot_reg, hold_slot_next;
    logic [hom_pkg::DELAY_W-1:0]    hold_delay_reg, hold_delay_next;
    logic                           m_valid_reg, m_valid_next;
    logic [hom_pkg::SLOT_W-1:0]     m_entry_slot_reg, m_entry_slot_next;
    logic [hom_pkg::DELAY_W-1:0]    m_overdue_time_reg, m_overdue_time_next;
    logic                           m_found_reg, m_found_next;
    logic                           m_last_reg, m_last_next;

    logic                 slot_ok;
    logic                 out_free;
    logic                 advance;
    logic [IDX_W-1:0]     cur_idx;
    logic                 mem_rd_en;
    logic [IDX_W-1:0]     mem_rd_addr;
    logic                 mem_wr_en;
    logic [ROW_W-1:0]     mem_rd_data;
    logic [ROW_W-1:0]     mem_wr_data;
    hom_pkg::act_t        act;
    logic [TIME_BITS-1:0] period_new, seen_new, pending_new, reported_new, delay;

    assign slot_ok  = (32'(s_slot) < NUM_ENTRIES);
    assign out_free = !m_valid_reg || m_ready;
    assign cur_idx  = (mode_reg == hom_pkg::MODE_CHECK) ? scan_idx_reg : slot_reg;
    // A second report can only be formed once the held one has somewhere to go.
    assign advance  = !act.report || !hold_valid_reg || out_free;

    hom_mem #(
        .DEPTH  (NUM_ENTRIES),
        .WIDTH  (ROW_W),
        .ADDR_W (IDX_W)
    ) u_hom_mem (
        .aclk    (aclk),
        .wr_en   (mem_wr_en),
        .wr_addr (cur_idx),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    hom_rules #(
        .TIME_BITS (TIME_BITS)
    ) u_hom_rules (
        .mode         (mode_reg),
        .ent_valid    (valid_reg[cur_idx]),
        .t            (time_reg),
        .ivl          (ivl_reg),
        .period       (mem_rd_data[4*TIME_BITS-1:3*TIME_BITS]),
        .seen         (mem_rd_data[3*TIME_BITS-1:2*TIME_BITS]),
        .pending      (mem_rd_data[2*TIME_BITS-1:TIME_BITS]),
        .reported     (mem_rd_data[TIME_BITS-1:0]),
        .act          (act),
        .period_new   (period_new),
        .seen_new     (seen_new),
        .pending_new  (pending_new),
        .reported_new (reported_new),
        .delay        (delay)
    );

    assign mem_wr_data = {period_new, seen_new, pending_new, reported_new};

    always_comb begin
        state_next          = state_reg;
        mode_next           = mode_reg;
        slot_next           = slot_reg;
        scan_idx_next       = scan_idx_reg;
        time_next           = time_reg;
        ivl_next            = ivl_reg;
        valid_next          = valid_reg;
        hold_valid_next     = hold_valid_reg;
        hold_slot_next      = hold_slot_reg;
        hold_delay_next     = hold_delay_reg;
        m_valid_next        = m_valid_reg && !m_ready;
        m_entry_slot_next   = m_entry_slot_reg;
        m_overdue_time_next = m_overdue_time_reg;
        m_found_next        = m_found_reg;
        m_last_next         = m_last_reg;
        mem_rd_en           = 1'b0;
        mem_rd_addr         = cur_idx;
        mem_wr_en           = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    mode_next     = s_mode;
                    slot_next     = IDX_W'(s_slot);
                    scan_idx_next = '0;
                    time_next     = TIME_BITS'(s_time_value);
                    ivl_next      = TIME_BITS'(s_interval_value);
                    // Unused mode and out-of-table slots are taken and dropped.
                    if ((s_mode == hom_pkg::MODE_CHECK) ||
                        (((s_mode == hom_pkg::MODE_DEFINE) ||
                          (s_mode == hom_pkg::MODE_UPDATE)) && slot_ok)) begin
                        state_next = ST_READ;
                    end
                end
            end
            ST_READ: begin
                mem_rd_en  = 1'b1;
                state_next = ST_EVAL;
            end
            ST_EVAL: begin
                if (mode_reg == hom_pkg::MODE_CHECK) begin
                    if (advance) begin
                        mem_wr_en = act.write;
                        if (act.report) begin
                            // The held report is not the final one: send it on.
                            if (hold_valid_reg) begin
                                m_valid_next        = 1'b1;
                                m_entry_slot_next   = hold_slot_reg;
                                m_overdue_time_next = hold_delay_reg;
                                m_found_next        = 1'b1;
                                m_last_next         = 1'b0;
                            end
                            hold_valid_next = 1'b1;
                            hold_slot_next  = hom_pkg::SLOT_W'(scan_idx_reg);
                            hold_delay_next = hom_pkg::DELAY_W'(delay);
                        end
                        if (scan_idx_reg == LAST_IDX) begin
                            state_next = ST_FINISH;
                        end else begin
                            scan_idx_next = scan_idx_reg + IDX_W'(1);
                            mem_rd_en     = 1'b1;
                            mem_rd_addr   = scan_idx_next;
                        end
                    end
                end else begin
                    mem_wr_en = act.write;
                    if (mode_reg == hom_pkg::MODE_DEFINE) begin
                        valid_next[slot_reg] = 1'b1;
                    end
                    state_next = ST_IDLE;
                end
            end
            ST_FINISH: begin
                if (out_free) begin
                    m_valid_next        = 1'b1;
                    m_entry_slot_next   = hold_valid_reg ? hold_slot_reg : '0;
                    m_overdue_time_next = hold_valid_reg ? hold_delay_reg : '0;
                    m_found_next        = hold_valid_reg;
                    m_last_next         = 1'b1;
                    hold_valid_next     = 1'b0;
                    state_next          = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            valid_reg      <= '0;
            hold_valid_reg <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            state_reg      <= state_next;
            valid_reg      <= valid_next;
            hold_valid_reg <= hold_valid_next;
            m_valid_reg    <= m_valid_next;
        end
        mode_reg           <= mode_next;
        slot_reg           <= slot_next;
        scan_idx_reg       <= scan_idx_next;
        time_reg           <= time_next;
        ivl_reg            <= ivl_next;
        hold_slot_reg      <= hold_slot_next;
        hold_delay_reg     <= hold_delay_next;
        m_entry_slot_reg   <= m_entry_slot_next;
        m_overdue_time_reg <= m_overdue_time_next;
        m_found_reg        <= m_found_next;
        m_last_reg         <= m_last_next;
    end

    assign s_ready        = (state_reg == ST_IDLE);
    assign m_valid        = m_valid_reg;
    assign m_entry_slot   = m_entry_slot_reg;
    assign m_overdue_time = m_overdue_time_reg;
    assign m_found        = m_found_reg;
    assign m_last         = m_last_reg;

endmodule

FILE: rtl/hom_checker.sv
`include "heartbeat_overdue_monitor_unit_macros.svh"

module hom_checker (
    input logic        aclk,
    input logic        aresetn,
    input logic        s_valid,
    input logic        s_ready,
    input logic [1:0]  s_mode,
    input logic [2:0]  s_slot,
    input logic [31:0] s_time_value,
    input logic [31:0] s_interval_value,
    input logic        m_valid,
    input logic        m_ready,
    input logic [2:0]  m_entry_slot,
    input logic [31:0] m_overdue_time,
    input logic        m_found,
    input logic        m_last
);

    // A stalled result keeps its contents.
    `HOM_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_entry_slot) && $stable(m_overdue_time) && $stable(m_found) && $stable(m_last), "result changed while stalled")

    // A check that finds nothing answers with one final, empty result.
    `HOM_ASSERT_IMPL(a_none_final, m_valid && !m_found, m_last && (m_entry_slot == 3'd0) && (m_overdue_time == 32'd0), "empty result is not final or not zero")

    // A request cannot be taken while a check is still producing results.
    `HOM_ASSERT_IMPL(a_no_take_mid_check, m_valid && !m_last, !s_ready, "request taken during a check")

    // Reset leaves no result on the output.
    `HOM_ASSERT_RESET(a_reset_clear, !aresetn, !m_valid, "result valid after reset")

endmodule

bind heartbeat_overdue_monitor_unit hom_checker u_hom_checker (.*);

FILE: dv/testbench.sv
module testbench;

    localparam int NUM_SLOTS = 8;
    localparam int RANDOM_ITEMS = 135;
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_CYCLES = 24;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    typedef struct packed {
        logic [1:0]                  mode;
        logic [hom_pkg::SLOT_W-1:0]  slot;
        logic [31:0]                 tstamp;
        logic [31:0]                 ival;
    } hb_req_t;

    typedef struct packed {
        logic [hom_pkg::SLOT_W-1:0]  slot;
        logic [hom_pkg::DELAY_W-1:0] delay;
        logic                        found;
        logic                        last;
    } overdue_rpt_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic [1:0]  s_mode = hom_pkg::MODE_DEFINE;
    logic [2:0]  s_slot = '0;
    logic [31:0] s_time_value = '0;
    logic [31:0] s_interval_value = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [2:0]  m_entry_slot;
    logic [31:0] m_overdue_time;
    logic        m_found;
    logic        m_last;

    heartbeat_overdue_monitor_unit u_dut (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_mode           (s_mode),
        .s_slot           (s_slot),
        .s_time_value     (s_time_value),
        .s_interval_value (s_interval_value),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_entry_slot     (m_entry_slot),
        .m_overdue_time   (m_overdue_time),
        .m_found          (m_found),
        .m_last           (m_last)
    );

    always #2 aclk = ~aclk;

    hb_req_t      req_fifo[$];
    overdue_rpt_t overdue_q[$];
    hb_req_t      next_req;
    bit           req_taken = 1'b0;
    int           err_cnt = 0;
    int           cycle_cnt = 0;

    // Shadow copy of the heartbeat table.
    bit          live_q[NUM_SLOTS];
    logic [31:0] period_q[NUM_SLOTS];
    logic [31:0] seen_q[NUM_SLOTS];
    logic [31:0] pend_q[NUM_SLOTS];
    logic [31:0] rep_q[NUM_SLOTS];

    // Generator-side view of which slots have been defined.
    bit          gen_live[NUM_SLOTS];
    logic [31:0] tbase;

    function automatic bit too_quiet(logic [31:0] t, logic [31:0] since,
                                     logic [31:0] lim);
        logic [31:0] gap;
        gap = t - since;
        return (t > since) && (gap > lim);
    endfunction

    function automatic void predict_request(hb_req_t rq);
        overdue_rpt_t hits[$];
        overdue_rpt_t rpt;
        logic [31:0]  t;
        t = rq.tstamp;
        case (rq.mode)
            hom_pkg::MODE_DEFINE: begin
                period_q[rq.slot] = rq.ival;
                if (!live_q[rq.slot]) begin
                    live_q[rq.slot] = 1'b1;
                    seen_q[rq.slot] = t;
                    pend_q[rq.slot] = '0;
                    rep_q[rq.slot] = '0;
                end
            end
            hom_pkg::MODE_UPDATE: begin
                if (live_q[rq.slot]) begin
                    if (too_quiet(t, seen_q[rq.slot], period_q[rq.slot]) &&
                        too_quiet(t, rep_q[rq.slot], period_q[rq.slot]))
                        pend_q[rq.slot] = t - seen_q[rq.slot];
                    seen_q[rq.slot] = t;
                end
            end
            hom_pkg::MODE_CHECK: begin
                for (int i = 0; i < NUM_SLOTS; i++) begin
                    if (live_q[i]) begin
                        rpt.slot = hom_pkg::SLOT_W'(i);
                        rpt.found = 1'b1;
                        rpt.last = 1'b0;
                        if (pend_q[i] != 0) begin
                            rpt.delay = pend_q[i];
                            hits.push_back(rpt);
                            pend_q[i] = '0;
                            rep_q[i] = t;
                        end else if (too_quiet(t, seen_q[i], period_q[i]) &&
                                     too_quiet(t, rep_q[i], period_q[i])) begin
                            rpt.delay = t - seen_q[i];
                            hits.push_back(rpt);
                            pend_q[i] = '0;
                            rep_q[i] = t - 32'd1;
                        end
                    end
                end
                if (hits.size() == 0) begin
                    rpt = '0;
                    rpt.last = 1'b1;
                    hits.push_back(rpt);
                end else begin
                    rpt = hits[hits.size()-1];
                    rpt.last = 1'b1;
                    hits[hits.size()-1] = rpt;
                end
                foreach (hits[k])
                    overdue_q.push_back(hits[k]);
            end
            default: ;
        endcase
    endfunction

    task automatic report_mismatch(string msg);
        err_cnt++;
        $display("MISMATCH @%0d: %s", cycle_cnt, msg);
    endtask

    task automatic add_req(logic [1:0] mode, logic [2:0] slot, logic [31:0] t,
                           logic [31:0] ivl);
        hb_req_t rq;
        rq.mode = mode;
        rq.slot = slot;
        rq.tstamp = t;
        rq.ival = ivl;
        req_fifo.push_back(rq);
        if (mode == hom_pkg::MODE_DEFINE)
            gen_live[slot] = 1'b1;
    endtask

    // No idling at all for a stretch in the middle of the run.
    function automatic bit take_break();
        if (cycle_cnt >= 400 && cycle_cnt < 900)
            return 1'b0;
        return $urandom_range(99) < 22;
    endfunction

    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt > CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    // Driver: note acceptance at the rising edge, change the inputs at the falling one.
    always @(posedge aclk) begin
        req_taken = aresetn && s_valid && (s_ready === 1'b1);
        if (req_taken)
            predict_request({s_mode, s_slot, s_time_value, s_interval_value});
    end

    always @(negedge aclk) begin
        if (aresetn && (!s_valid || req_taken)) begin
            if (req_fifo.size() != 0 && !take_break()) begin
                next_req = req_fifo.pop_front();
                s_valid <= 1'b1;
                s_mode <= next_req.mode;
                s_slot <= next_req.slot;
                s_time_value <= next_req.tstamp;
                s_interval_value <= next_req.ival;
            end else begin
                s_valid <= 1'b0;
            end
        end
    end

    // Monitor: compare each accepted result with the oldest expectation.
    always @(posedge aclk) begin
        if (aresetn && m_valid === 1'b1 && m_ready) begin
            if (overdue_q.size() == 0) begin
                report_mismatch($sformatf("unexpected result slot=%0d delay=%0d",
                                          m_entry_slot, m_overdue_time));
            end else begin
                if (m_entry_slot !== overdue_q[0].slot)
                    report_mismatch($sformatf("entry_slot got %0d want %0d",
                                              m_entry_slot, overdue_q[0].slot));
                if (m_overdue_time !== overdue_q[0].delay)
                    report_mismatch($sformatf("overdue_time got %0d want %0d",
                                              m_overdue_time, overdue_q[0].delay));
                if (m_found !== overdue_q[0].found)
                    report_mismatch($sformatf("found got %b want %b",
                                              m_found, overdue_q[0].found));
                if (m_last !== overdue_q[0].last)
                    report_mismatch($sformatf("last got %b want %b",
                                              m_last, overdue_q[0].last));
                void'(overdue_q.pop_front());
            end
        end
    end

    always @(negedge aclk)
        m_ready <= !take_break();

    initial begin
        int counted;
        int r;
        int sl;
        logic [31:0] ivl;

        // Directed part: field extremes, every mode and the corner cases.
        add_req(hom_pkg::MODE_CHECK, 3'd0, 32'd10, 32'd0);         // empty table
        add_req(hom_pkg::MODE_UPDATE, 3'd5, 32'd5, 32'd0);         // update of undefined entry
        add_req(hom_pkg::MODE_DEFINE, 3'd0, 32'd100, 32'd10);
        add_req(hom_pkg::MODE_DEFINE, 3'd7, 32'd0, 32'd0);
        add_req(hom_pkg::MODE_DEFINE, 3'd3, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        add_req(hom_pkg::MODE_CHECK, 3'd7, 32'd50, 32'hFFFF_FFFF);
        add_req(hom_pkg::MODE_UPDATE, 3'd0, 32'd200, 32'hFFFF_FFFF); // long silence latched
        add_req(MODE_UNUSED, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF);    // ignored
        add_req(hom_pkg::MODE_DEFINE, 3'd0, 32'd0, 32'd5);         // redefine keeps times
        add_req(hom_pkg::MODE_CHECK, 3'd0, 32'd201, 32'd0);
        add_req(hom_pkg::MODE_CHECK, 3'd0, 32'd201, 32'd0);
        add_req(hom_pkg::MODE_UPDATE, 3'd3, 32'd0, 32'd0);         // heartbeat behind last-seen
        add_req(hom_pkg::MODE_UPDATE, 3'd7, 32'hFFFF_FFFF, 32'd0);
        add_req(hom_pkg::MODE_CHECK, 3'd0, 32'hFFFF_FFFF, 32'd0);
        add_req(hom_pkg::MODE_DEFINE, 3'd1, 32'd1000, 32'd3);
        add_req(hom_pkg::MODE_UPDATE, 3'd1, 32'd1002, 32'd0);      // within interval
        add_req(hom_pkg::MODE_UPDATE, 3'd1, 32'd1010, 32'd0);      // overdue heartbeat
        add_req(hom_pkg::MODE_UPDATE, 3'd1, 32'd1020, 32'd0);      // second one overwrites
        add_req(hom_pkg::MODE_CHECK, 3'd0, 32'd1021, 32'd0);
        add_req(hom_pkg::MODE_CHECK, 3'd0, 32'd0, 32'd0);          // time before everything
        add_req(MODE_UNUSED, 3'd0, 32'd0, 32'd0);

        // Random part: mostly heartbeats on a moving time base, with checks between.
        tbase = $urandom();
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            r = $urandom_range(99);
            sl = $urandom_range(NUM_SLOTS - 1);
            if ($urandom_range(9) != 0)
                for (int k = 0; k < NUM_SLOTS && !gen_live[sl]; k++)
                    sl = (sl + 1) % NUM_SLOTS;
            if (r < 10) begin
                ivl = ($urandom_range(7) == 0) ? $urandom() : $urandom_range(1, 40);
                add_req(hom_pkg::MODE_DEFINE, 3'(sl), tbase, ivl);
                counted++;
            end else if (r < 60) begin
                tbase = tbase + $urandom_range(0, 30);
                if ($urandom_range(9) == 0)
                    add_req(hom_pkg::MODE_UPDATE, 3'(sl), tbase - $urandom_range(0, 60),
                            $urandom());
                else
                    add_req(hom_pkg::MODE_UPDATE, 3'(sl), tbase, $urandom());
                counted++;
            end else if (r < 82) begin
                tbase = tbase + $urandom_range(0, 30);
                add_req(hom_pkg::MODE_CHECK, 3'(sl), tbase, $urandom());
                counted++;
            end else if (r < 86) begin
                add_req(MODE_UNUSED, 3'($urandom()), $urandom(), $urandom());
            end else begin
                add_req(2'($urandom_range(2)), 3'($urandom()), $urandom(), $urandom());
                counted++;
            end
        end

        repeat (3) @(posedge aclk);
        @(negedge aclk) aresetn <= 1'b1;

        while (!(req_fifo.size() == 0 && !s_valid && overdue_q.size() == 0))
            @(negedge aclk);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (overdue_q.size() != 0)
            report_mismatch($sformatf("%0d results never arrived", overdue_q.size()));

        if (err_cnt == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

endmodule
